@@ hw/rtl/deq_pkg.sv @@
package deq_pkg;

    localparam int DEPTH   = 8;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int CAP_W   = 4;
    localparam int OP_W    = 3;
    localparam int STAT_W  = 2;

    localparam logic [CAP_W-1:0]         CAP_RESET  = CAP_W'(8);
    localparam logic signed [DATA_W-1:0] NONE_VALUE = '1;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_QUERY      = 3'd4
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE       = 2'd0,
        ST_FULL_REJ   = 2'd1,
        ST_EMPTY_REJ  = 2'd2
    } status_t;

    typedef struct packed {
        logic                     we;
        logic [IDX_W-1:0]         waddr;
        logic signed [DATA_W-1:0] wdata;
        logic [IDX_W-1:0]         raddr_head;
        logic [IDX_W-1:0]         raddr_tail;
    } mem_req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] head_data;
        logic signed [DATA_W-1:0] tail_data;
    } mem_rsp_t;

    function automatic logic [CNT_W-1:0] clamp_cap(input logic [CAP_W-1:0] c);
        logic [CNT_W-1:0] r;
        if (c == '0)
            r = CNT_W'(1);
        else if (int'(c) > DEPTH)
            r = CNT_W'(DEPTH);
        else
            r = CNT_W'(c);
        return r;
    endfunction

    function automatic logic [IDX_W-1:0] step_up(input logic [IDX_W-1:0] idx,
                                                 input logic [CNT_W-1:0] used);
        logic [CNT_W-1:0] n;
        n = CNT_W'(idx) + CNT_W'(1);
        return (n >= used) ? '0 : n[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0] idx,
                                                   input logic [CNT_W-1:0] used);
        logic [CNT_W-1:0] top;
        top = used - CNT_W'(1);
        if (idx == '0 || CNT_W'(idx) >= used)
            return top[IDX_W-1:0];
        return idx - IDX_W'(1);
    endfunction

endpackage

@@ hw/rtl/deq_in_if.sv @@
interface deq_in_if;
    logic                              valid;
    logic                              ready;
    logic [deq_pkg::OP_W-1:0]          operation;
    logic signed [deq_pkg::DATA_W-1:0] data_in;

    modport source (output valid, output operation, output data_in, input ready);
    modport sink   (input valid, input operation, input data_in, output ready);
endinterface

@@ hw/rtl/deq_out_if.sv @@
interface deq_out_if;
    logic                              valid;
    logic                              ready;
    logic [deq_pkg::STAT_W-1:0]        status;
    logic signed [deq_pkg::DATA_W-1:0] head_value;
    logic signed [deq_pkg::DATA_W-1:0] tail_value;
    logic                              is_empty;
    logic                              is_full;

    modport source (output valid, output status, output head_value, output tail_value,
                    output is_empty, output is_full, input ready);
    modport sink   (input valid, input status, input head_value, input tail_value,
                    input is_empty, input is_full, output ready);
endinterface

@@ hw/rtl/deq_cfg_if.sv @@
interface deq_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [deq_pkg::CAP_W-1:0]  capacity;

    modport source (output valid, output capacity, input ready);
    modport sink   (input valid, input capacity, output ready);
endinterface

@@ hw/rtl/double_ended_queue_ring_top.sv @@
// An accepted transaction writes its slot and updates the indices, S_READ reads both
// ends, and S_CAP captures the result into the output register that drives rsp, waiting
// while an earlier result there is not taken. No new one is accepted until that capture.
// A finished result waits in the output register while the next one is accepted.
// Reset: indices zero, deque empty, capacity 8; slot contents undefined, no clear pass.
module double_ended_queue_ring_top (
    input  logic      clk,
    input  logic      rst_n,
    deq_in_if.sink    req,
    deq_out_if.source rsp,
    deq_cfg_if.sink   cfg
);
    import deq_pkg::*;

    mem_req_t mem_req;
    mem_rsp_t mem_rsp;

    deq_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .cfg     (cfg),
        .mem_req (mem_req),
        .mem_rsp (mem_rsp)
    );

    deq_store u_store (
        .clk     (clk),
        .mem_req (mem_req),
        .mem_rsp (mem_rsp)
    );

endmodule

@@ hw/rtl/deq_store.sv @@
module deq_store (
    input  logic              clk,
    input  deq_pkg::mem_req_t mem_req,
    output deq_pkg::mem_rsp_t mem_rsp
);
    import deq_pkg::*;

    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [DATA_W-1:0] head_data_reg;
    logic signed [DATA_W-1:0] tail_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            mem[mem_req.waddr] <= mem_req.wdata;
        end
        head_data_reg <= mem[mem_req.raddr_head];
        tail_data_reg <= mem[mem_req.raddr_tail];
    end

    assign mem_rsp.head_data = head_data_reg;
    assign mem_rsp.tail_data = tail_data_reg;

endmodule

@@ hw/rtl/deq_ctrl.sv @@
module deq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    deq_in_if.sink            req,
    deq_out_if.source         rsp,
    deq_cfg_if.sink           cfg,
    output deq_pkg::mem_req_t mem_req,
    input  deq_pkg::mem_rsp_t mem_rsp
);
    import deq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_CAP  = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic             empty_reg, empty_next;
    logic [CNT_W-1:0] used_reg, used_next;
    status_t          stat_reg, stat_next;

    logic                     rsp_valid_reg, rsp_valid_next;
    logic [STAT_W-1:0]        rsp_status_reg;
    logic signed [DATA_W-1:0] rsp_head_reg;
    logic signed [DATA_W-1:0] rsp_tail_reg;
    logic                     rsp_empty_reg;
    logic                     rsp_full_reg;

    logic req_fire;
    logic cfg_fire;
    logic cap_load;
    logic full_now;

    assign cfg.ready = (state_reg == S_IDLE);
    assign req.ready = (state_reg == S_IDLE) && !cfg.valid;
    assign cfg_fire  = cfg.valid && cfg.ready;
    assign req_fire  = req.valid && req.ready;
    assign full_now  = !empty_reg && (step_up(tail_reg, used_reg) == head_reg);
    assign cap_load  = (state_reg == S_CAP) && (!rsp_valid_reg || rsp.ready);

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        empty_next      = empty_reg;
        used_next       = used_reg;
        stat_next       = stat_reg;
        mem_req.we      = 1'b0;
        mem_req.waddr   = '0;
        mem_req.wdata   = req.data_in;
        mem_req.raddr_head = head_reg;
        mem_req.raddr_tail = tail_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_fire)
                begin
                    used_next  = clamp_cap(cfg.capacity);
                    head_next  = '0;
                    tail_next  = '0;
                    empty_next = 1'b1;
                end
                else if (req_fire)
                begin
                    stat_next  = ST_DONE;
                    state_next = S_READ;
                    unique case (req.operation)
                        OP_PUSH_FRONT, OP_PUSH_BACK:
                        begin
                            if (full_now)
                            begin
                                stat_next = ST_FULL_REJ;
                            end
                            else if (empty_reg)
                            begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = '0;
                                head_next     = '0;
                                tail_next     = '0;
                                empty_next    = 1'b0;
                            end
                            else if (req.operation == OP_PUSH_FRONT)
                            begin
                                head_next     = step_down(head_reg, used_reg);
                                mem_req.we    = 1'b1;
                                mem_req.waddr = head_next;
                            end
                            else
                            begin
                                tail_next     = step_up(tail_reg, used_reg);
                                mem_req.we    = 1'b1;
                                mem_req.waddr = tail_next;
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK:
                        begin
                            if (empty_reg)
                            begin
                                stat_next = ST_EMPTY_REJ;
                            end
                            else if (head_reg == tail_reg)
                            begin
                                head_next  = '0;
                                tail_next  = '0;
                                empty_next = 1'b1;
                            end
                            else if (req.operation == OP_POP_FRONT)
                            begin
                                head_next = step_up(head_reg, used_reg);
                            end
                            else
                            begin
                                tail_next = step_down(tail_reg, used_reg);
                            end
                        end
                        default:
                        begin
                            stat_next = ST_DONE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                state_next = S_CAP;
            end
            S_CAP:
            begin
                if (cap_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp.valid && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (cap_load)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            empty_reg     <= 1'b1;
            used_reg      <= clamp_cap(CAP_RESET);
            stat_reg      <= ST_DONE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            empty_reg     <= empty_next;
            used_reg      <= used_next;
            stat_reg      <= stat_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // hold the result until the sink takes it
    always_ff @(posedge clk)
    begin
        if (cap_load)
        begin
            rsp_status_reg <= stat_reg;
            rsp_empty_reg  <= empty_reg;
            rsp_full_reg   <= full_now;
            rsp_head_reg   <= empty_reg ? NONE_VALUE : mem_rsp.head_data;
            rsp_tail_reg   <= empty_reg ? NONE_VALUE : mem_rsp.tail_data;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.status     = rsp_status_reg;
    assign rsp.head_value = rsp_head_reg;
    assign rsp.tail_value = rsp_tail_reg;
    assign rsp.is_empty   = rsp_empty_reg;
    assign rsp.is_full    = rsp_full_reg;

`ifndef NO_ASSERTIONS
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (CNT_W'(head_reg) < used_reg) && (CNT_W'(tail_reg) < used_reg))
        else $error("deque index beyond capacity");

    a_empty_idx: assert property (@(posedge clk) disable iff (!rst_n)
        empty_reg |-> (head_reg == '0) && (tail_reg == '0))
        else $error("empty deque with nonzero index");

    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.we |-> (state_reg == S_IDLE) && req_fire)
        else $error("slot write outside an accepted transaction");

    a_cap_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CAP) && rsp_valid_reg && !rsp.ready |=> (state_reg == S_CAP))
        else $error("result dropped while output stalled");

    a_read_to_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |=> (state_reg == S_CAP) && $stable(head_reg))
        else $error("read stage not followed by capture");
`endif

endmodule

@@ dv/deq_result_check.sv @@
module deq_result_check (
    input  logic clk,
    input  logic rst_n,
    deq_in_if    req,
    deq_out_if   rsp,
    deq_cfg_if   cfg,
    output int   errors,
    output int   pending
);
    import deq_pkg::*;

    typedef struct {
        status_t                  status;
        logic signed [DATA_W-1:0] head_value;
        logic signed [DATA_W-1:0] tail_value;
        logic                     is_empty;
        logic                     is_full;
    } deq_result_t;

    logic signed [DATA_W-1:0] ring_slots [DEPTH];
    logic [IDX_W-1:0]         front_ix;
    logic [IDX_W-1:0]         back_ix;
    logic                     ring_empty;
    logic [CAP_W-1:0]         ring_cap;

    deq_result_t expected_q [$];
    deq_result_t fresh;
    deq_result_t oldest;
    int          fail_count = 0;

    assign errors = fail_count;

    function automatic int ring_size();
        int c;
        c = int'(ring_cap);
        if (c == 0)
            c = 1;
        if (c > DEPTH)
            c = DEPTH;
        return c;
    endfunction

    function automatic logic [IDX_W-1:0] next_ix(input logic [IDX_W-1:0] ix);
        int n;
        n = int'(ix) + 1;
        return (n >= ring_size()) ? '0 : IDX_W'(n);
    endfunction

    function automatic logic [IDX_W-1:0] prev_ix(input logic [IDX_W-1:0] ix);
        int c;
        c = ring_size();
        if (ix == '0 || int'(ix) >= c)
            return IDX_W'(c - 1);
        return ix - IDX_W'(1);
    endfunction

    function automatic logic ring_full();
        return !ring_empty && next_ix(back_ix) == front_ix;
    endfunction

    task automatic report(input string what, input logic [DATA_W-1:0] got,
                          input logic [DATA_W-1:0] want);
        $display("%0t: result mismatch on %s: got %h, want %h", $time, what, got, want);
        fail_count++;
    endtask

    task automatic apply_request(input logic [OP_W-1:0] op,
                                 input logic signed [DATA_W-1:0] data,
                                 output deq_result_t r);
        r.status = ST_DONE;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (ring_full())
                    r.status = ST_FULL_REJ;
                else if (ring_empty)
                begin
                    ring_slots[0] = data;
                    front_ix = '0;
                    back_ix = '0;
                    ring_empty = 1'b0;
                end
                else if (op == OP_PUSH_FRONT)
                begin
                    front_ix = prev_ix(front_ix);
                    ring_slots[front_ix] = data;
                end
                else
                begin
                    back_ix = next_ix(back_ix);
                    ring_slots[back_ix] = data;
                end
            end
            OP_POP_FRONT, OP_POP_BACK:
            begin
                if (ring_empty)
                    r.status = ST_EMPTY_REJ;
                else if (front_ix == back_ix)
                begin
                    front_ix = '0;
                    back_ix = '0;
                    ring_empty = 1'b1;
                end
                else if (op == OP_POP_FRONT)
                    front_ix = next_ix(front_ix);
                else
                    back_ix = prev_ix(back_ix);
            end
            default:
            begin
            end
        endcase
        r.head_value = ring_empty ? NONE_VALUE : ring_slots[front_ix];
        r.tail_value = ring_empty ? NONE_VALUE : ring_slots[back_ix];
        r.is_empty = ring_empty;
        r.is_full = ring_full();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
                ring_slots[i] = '0;
            front_ix = '0;
            back_ix = '0;
            ring_empty = 1'b1;
            ring_cap = CAP_RESET;
            expected_q.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                ring_cap = cfg.capacity;
                front_ix = '0;
                back_ix = '0;
                ring_empty = 1'b1;
            end
            if (req.valid && req.ready)
            begin
                apply_request(req.operation, req.data_in, fresh);
                expected_q = {expected_q, fresh};
            end
            if (rsp.valid && rsp.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: result transaction with nothing expected", $time);
                    fail_count++;
                end
                else
                begin
                    oldest = expected_q[0];
                    expected_q.delete(0);
                    if (rsp.status !== oldest.status)
                        report("status", DATA_W'(rsp.status), DATA_W'(oldest.status));
                    if (rsp.head_value !== oldest.head_value)
                        report("head_value", rsp.head_value, oldest.head_value);
                    if (rsp.tail_value !== oldest.tail_value)
                        report("tail_value", rsp.tail_value, oldest.tail_value);
                    if (rsp.is_empty !== oldest.is_empty)
                        report("is_empty", DATA_W'(rsp.is_empty), DATA_W'(oldest.is_empty));
                    if (rsp.is_full !== oldest.is_full)
                        report("is_full", DATA_W'(rsp.is_full), DATA_W'(oldest.is_full));
                end
            end
            pending <= expected_q.size();
        end
    end

endmodule

@@ dv/tb_top.sv @@
module tb_top;

    import deq_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 3'd7;
    localparam int RANDOM_ITEMS   = 1300;
    localparam int SQUEEZE_CYCLES = 80;
    localparam int SQUEEZE_PHASE  = 2;

    logic clk = 1'b0;
    logic rst_n;

    bit steady = 1'b0;
    bit squeeze = 1'b0;
    int errors;
    int pending;

    deq_in_if  req_if ();
    deq_out_if rsp_if ();
    deq_cfg_if cfg_if ();

    double_ended_queue_ring_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    deq_result_check result_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_if),
        .rsp     (rsp_if),
        .cfg     (cfg_if),
        .errors  (errors),
        .pending (pending)
    );

    always #10 clk = ~clk;

    function automatic int next_gap();
        int r;
        if (steady || squeeze)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    task automatic send_req(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] data,
                            input int gap);
        req_if.valid <= 1'b1;
        req_if.operation <= op;
        req_if.data_in <= data;
        do
            @(posedge clk);
        while (!req_if.ready);
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        wait_drained();
        cfg_if.valid <= 1'b1;
        cfg_if.capacity <= cap;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    // result side: random back-pressure, steady phases and one long hold-off
    initial
    begin
        int r;
        int n;
        rsp_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (squeeze)
            begin
                rsp_if.ready <= 1'b0;
                repeat (SQUEEZE_CYCLES) @(posedge clk);
                squeeze = 1'b0;
            end
            else if (steady)
            begin
                rsp_if.ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 65)
                begin
                    rsp_if.ready <= 1'b1;
                    n = $urandom_range(1, 4);
                end
                else
                begin
                    rsp_if.ready <= 1'b0;
                    n = (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 30);
                end
                repeat (n) @(posedge clk);
            end
        end
    end

    initial
    begin
        logic [CAP_W-1:0] fixed_caps [11] = '{4'd1, 4'd0, 4'd15, 4'd9, 4'd2, 4'd3,
                                              4'd5, 4'd8, 4'd7, 4'd4, 4'd6};
        logic [CAP_W-1:0] cap;
        logic [OP_W-1:0]  op;
        logic [DATA_W-1:0] data;
        int sent;
        int phase;
        int len;
        int mood;
        int mood_left;
        int push_pct;
        int r;

        rst_n <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.operation <= OP_QUERY;
        req_if.data_in <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.capacity <= CAP_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty deque, fill to full at reset capacity, reject, unused opcodes, drain to empty
        send_req(OP_QUERY, $urandom, next_gap());
        send_req(OP_POP_FRONT, $urandom, next_gap());
        send_req(OP_POP_BACK, $urandom, next_gap());
        send_req(OP_PUSH_BACK, 32'h7fff_ffff, next_gap());
        send_req(OP_PUSH_FRONT, 32'h8000_0000, next_gap());
        send_req(OP_PUSH_BACK, 32'h0000_0000, next_gap());
        send_req(OP_PUSH_FRONT, 32'hffff_ffff, next_gap());
        send_req(OP_PUSH_BACK, 32'h5555_5555, next_gap());
        send_req(OP_PUSH_FRONT, 32'haaaa_aaaa, next_gap());
        send_req(OP_PUSH_BACK, 32'h0000_0001, next_gap());
        send_req(OP_PUSH_FRONT, $urandom, next_gap());
        send_req(OP_PUSH_BACK, $urandom, next_gap());
        send_req(OP_PUSH_FRONT, $urandom, next_gap());
        send_req(OP_UNUSED_FIRST, $urandom, next_gap());
        send_req(OP_UNUSED_FIRST + 3'd1, $urandom, next_gap());
        send_req(OP_UNUSED_LAST, $urandom, next_gap());
        send_req(OP_POP_FRONT, $urandom, next_gap());
        send_req(OP_POP_BACK, $urandom, next_gap());
        send_req(OP_POP_FRONT, $urandom, next_gap());
        send_req(OP_POP_BACK, $urandom, next_gap());
        send_req(OP_POP_FRONT, $urandom, next_gap());
        send_req(OP_POP_BACK, $urandom, next_gap());
        send_req(OP_POP_FRONT, $urandom, next_gap());
        send_req(OP_POP_BACK, $urandom, next_gap());
        send_req(OP_POP_FRONT, $urandom, next_gap());
        req_if.valid <= 1'b0;

        sent = 0;
        phase = 0;
        mood_left = 0;
        while (sent < RANDOM_ITEMS)
        begin
            cap = (phase < 11) ? fixed_caps[phase] : CAP_W'($urandom_range(0, 15));
            write_capacity(cap);
            steady = (phase % 4 == 3);
            if (phase == SQUEEZE_PHASE)
                squeeze = 1'b1;
            len = $urandom_range(40, 120);
            for (int i = 0; i < len; i++)
            begin
                if (mood_left == 0)
                begin
                    mood = $urandom_range(0, 2);
                    mood_left = $urandom_range(5, 20);
                end
                mood_left--;
                push_pct = (mood == 0) ? 70 : (mood == 1) ? 20 : 47;
                r = $urandom_range(0, 99);
                if (r < 3)
                    op = OP_QUERY;
                else if (r < 6)
                    op = OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
                else if (r < 6 + push_pct)
                    op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
                else
                    op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
                r = $urandom_range(0, 9);
                if (r == 0)
                    data = 32'h8000_0000;
                else if (r == 1)
                    data = 32'h7fff_ffff;
                else if (r == 2)
                    data = '1;
                else
                    data = $urandom;
                send_req(op, data, next_gap());
            end
            req_if.valid <= 1'b0;
            sent += len;
            phase++;
        end

        steady = 1'b0;
        wait_drained();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("** double_ended_queue_ring_top: PASSED **");
        else
            $display("** double_ended_queue_ring_top: FAILED **");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("** double_ended_queue_ring_top: FAILED **");
        $finish;
    end

endmodule
